// ----- hdl/csp_pkg.sv -----
// Shared types and constants for the compass sentence parser.
// No dependencies.
`default_nettype none
package csp_pkg;
	localparam int VALUE_BITS = 24;
	localparam int COUNT_BITS = 16;
	localparam int NUM_FIELDS = 6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_Y      = 8'h59;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// one frame-end record handed to the back end
	typedef struct packed {
		logic ok;
		logic [NUM_FIELDS*VALUE_BITS-1:0] values;
		logic [2:0] flags;
	} frame_rec_t;

	// hex digit of a nibble, upper case
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		hex_char = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction
endpackage
`default_nettype wire

// ----- hdl/csp_front.sv -----
// Front end: framing, checksum and field parsing, one byte per cycle unless stalled.
// Depends on csp_pkg. Emits one frame record per frame end.
`default_nettype none
module csp_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [7:0] rx_byte,
	input  wire logic rx_valid,
	output logic rx_ready,
	output logic rec_valid,
	output csp_pkg::frame_rec_t rec,
	input  wire logic rec_ready,
	input  wire logic [csp_pkg::NUM_FIELDS*csp_pkg::VALUE_BITS-1:0] committed_values,
	input  wire logic [2:0] committed_flags
);
	import csp_pkg::*;

	typedef enum logic [2:0] {PH_IDLE, PH_BODY, PH_HEX1, PH_HEX2, PH_CR, PH_LF} phase_t;
	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_FLAGS = 3'd7;
	localparam logic [VALUE_BITS:0] CAP = (VALUE_BITS+1)'(1) << (VALUE_BITS-1);

	phase_t phase_q;
	logic [7:0] xor_q;
	logic [15:0] hex_q;
	logic [2:0] key_q;
	logic [VALUE_BITS:0] acc_q;
	logic neg_q, point_q, started_q, bad_q, fresh_q;
	logic [1:0] frac_q, foff_q;
	logic [NUM_FIELDS*VALUE_BITS-1:0] pend_q;
	logic [2:0] pflags_q;

	logic fire;
	assign rx_ready = !rec_valid || rec_ready;
	assign fire = rx_valid && rx_ready;

	// times ten plus one digit, saturating at CAP
	function automatic logic [VALUE_BITS:0] mac(input logic [VALUE_BITS:0] a,
			input logic [3:0] d);
		logic [VALUE_BITS+4:0] r;
		r = {4'd0, a} * (VALUE_BITS+5)'(10) + (VALUE_BITS+5)'(d);
		mac = (r > (VALUE_BITS+5)'(CAP)) ? CAP : r[VALUE_BITS:0];
	endfunction

	logic [VALUE_BITS:0] m1, m2;
	logic [VALUE_BITS-1:0] close_val;
	always_comb begin
		m1 = (frac_q == 2'd0) ? mac(acc_q, 4'd0) : acc_q;
		m2 = (frac_q != 2'd2) ? mac(m1, 4'd0) : m1;
		if (bad_q || !started_q)
			close_val = '0;
		else if (neg_q)
			close_val = VALUE_BITS'(-m2);
		else
			close_val = (m2 >= CAP) ? VALUE_BITS'(CAP - (VALUE_BITS+1)'(1)) :
				m2[VALUE_BITS-1:0];
	end

	// pending base: on the first byte after start it is the committed copy
	logic [NUM_FIELDS*VALUE_BITS-1:0] pend_base, pend_closed;
	logic [2:0] pflags_base;
	always_comb begin
		pend_base = fresh_q ? committed_values : pend_q;
		pflags_base = fresh_q ? committed_flags : pflags_q;
		pend_closed = pend_base;
		for (int i = 0; i < NUM_FIELDS; i++)
			if (key_q == 3'(i + 1))
				pend_closed[i*VALUE_BITS +: VALUE_BITS] = close_val;
	end

	function automatic logic [2:0] key_of(input logic [7:0] c);
		case (c)
			CH_C: key_of = 3'd1;
			CH_P: key_of = 3'd2;
			CH_R: key_of = 3'd3;
			CH_X: key_of = 3'd4;
			CH_Y: key_of = 3'd5;
			CH_Z: key_of = 3'd6;
			CH_E: key_of = KEY_FLAGS;
			default: key_of = KEY_NONE;
		endcase
	endfunction

	logic is_crlf;
	assign is_crlf = (rx_byte == CH_CR) || (rx_byte == CH_LF);

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rec_valid <= 1'b0;
			rec <= '0;
			fresh_q <= 1'b0;
			key_q <= KEY_NONE;
			xor_q <= '0;
			hex_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			point_q <= 1'b0;
			started_q <= 1'b0;
			bad_q <= 1'b0;
			frac_q <= '0;
			foff_q <= '0;
			pend_q <= '0;
			pflags_q <= '0;
		end else begin
			if (rec_ready) rec_valid <= 1'b0;
			if (fire) begin
				if (rx_byte == CH_DOLLAR) begin
					if (phase_q != PH_IDLE) begin
						rec_valid <= 1'b1;
						rec.ok <= 1'b0;
					end
					phase_q <= PH_BODY;
					xor_q <= '0;
					hex_q <= '0;
					key_q <= KEY_NONE;
					fresh_q <= 1'b1;
				end else begin
					case (phase_q)
						PH_BODY: begin
							fresh_q <= 1'b0;
							pend_q <= pend_base;
							pflags_q <= pflags_base;
							if (is_crlf) begin
								rec_valid <= 1'b1; rec.ok <= 1'b0; phase_q <= PH_IDLE;
							end else if (rx_byte == CH_STAR) begin
								pend_q <= pend_closed;
								key_q <= KEY_NONE;
								phase_q <= PH_HEX1;
							end else begin
								xor_q <= xor_q ^ rx_byte;
								if (key_of(rx_byte) != KEY_NONE) begin
									pend_q <= pend_closed;
									key_q <= key_of(rx_byte);
									acc_q <= '0; neg_q <= 1'b0; frac_q <= '0;
									point_q <= 1'b0; foff_q <= '0;
									started_q <= 1'b0; bad_q <= 1'b0;
								end else if (key_q == KEY_FLAGS) begin
									if (foff_q != 2'd3) begin
										foff_q <= foff_q + 2'd1;
										if (foff_q == 2'd2) pflags_q <= rx_byte[2:0];
									end
								end else if (key_q != KEY_NONE && !bad_q) begin
									if ((rx_byte == CH_MINUS || rx_byte == CH_PLUS) &&
										!started_q) begin
										neg_q <= rx_byte == CH_MINUS;
										started_q <= 1'b1;
									end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
										if (!(point_q && frac_q == 2'd2)) begin
											acc_q <= mac(acc_q, rx_byte[3:0]);
											if (point_q) frac_q <= frac_q + 2'd1;
										end
										started_q <= 1'b1;
									end else if (rx_byte == CH_POINT && !point_q) begin
										point_q <= 1'b1;
										started_q <= 1'b1;
									end else
										bad_q <= 1'b1;
								end
							end
						end
						PH_HEX1, PH_HEX2: begin
							if (is_crlf) begin
								rec_valid <= 1'b1; rec.ok <= 1'b0; phase_q <= PH_IDLE;
							end else begin
								hex_q <= {hex_q[7:0], rx_byte};
								phase_q <= (phase_q == PH_HEX1) ? PH_HEX2 : PH_CR;
							end
						end
						PH_CR: begin
							if (rx_byte != CH_CR) begin
								rec_valid <= 1'b1; rec.ok <= 1'b0; phase_q <= PH_IDLE;
							end else
								phase_q <= PH_LF;
						end
						PH_LF: begin
							// payload follows the pending set closed at the star
							rec_valid <= 1'b1;
							rec.ok <= (rx_byte == CH_LF) &&
								(hex_q == {hex_char(xor_q[7:4]), hex_char(xor_q[3:0])});
							rec.values <= pend_q;
							rec.flags <= pflags_q;
							phase_q <= PH_IDLE;
						end
						default: ;
					endcase
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/csp_back.sv -----
// Back end: commit of valid frames, counters, result register.
// Depends on csp_pkg.
`default_nettype none
module csp_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic rec_valid,
	input  wire csp_pkg::frame_rec_t rec,
	output logic rec_ready,
	output logic [csp_pkg::NUM_FIELDS*csp_pkg::VALUE_BITS-1:0] committed_q,
	output logic [2:0] cflags_q,
	output logic out_valid,
	input  wire logic out_ready,
	output logic out_ok,
	output logic [csp_pkg::COUNT_BITS-1:0] good_q,
	output logic [csp_pkg::COUNT_BITS-1:0] bad_q
);
	import csp_pkg::*;

	// committed state is applied when a record is taken, so the front always
	// sees committed values current as of every accepted frame
	assign rec_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q <= '0;
			cflags_q <= '0;
			good_q <= '0;
			bad_q <= '0;
			out_valid <= 1'b0;
			out_ok <= 1'b0;
		end else begin
			if (out_ready) out_valid <= 1'b0;
			if (rec_valid && rec_ready) begin
				out_valid <= 1'b1;
				out_ok <= rec.ok;
				if (rec.ok) begin
					committed_q <= rec.values;
					cflags_q <= rec.flags;
					good_q <= good_q + COUNT_BITS'(1);
				end else
					bad_q <= bad_q + COUNT_BITS'(1);
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/compass_sentence_parser.sv -----
// Compass sentence parser, one received byte per cycle (back to back) while not stalled.
// A frame's final byte loads the record; out_valid rises when the back end takes it.
// Throughput set by the front-end byte sequencer: one byte per clock unless stalled.
// Frame record and result registers decouple the two sides.
// Reset (arst_n, async): idle, all values, flags and counters zero.
`default_nettype none
module compass_sentence_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [7:0] rx_byte,
	output logic out_valid,
	input  wire logic out_ready,
	output logic frame_ok,
	output logic signed [csp_pkg::VALUE_BITS-1:0] heading,
	output logic signed [csp_pkg::VALUE_BITS-1:0] pitch_angle,
	output logic signed [csp_pkg::VALUE_BITS-1:0] roll_angle,
	output logic signed [csp_pkg::VALUE_BITS-1:0] mag_x,
	output logic signed [csp_pkg::VALUE_BITS-1:0] mag_y,
	output logic signed [csp_pkg::VALUE_BITS-1:0] mag_z,
	output logic magnetic_distortion,
	output logic tilt_out_of_range,
	output logic mag_out_of_range,
	output logic [csp_pkg::COUNT_BITS-1:0] good_frames,
	output logic [csp_pkg::COUNT_BITS-1:0] bad_frames
);
	import csp_pkg::*;

	logic rec_valid, rec_ready;
	frame_rec_t rec;
	logic [NUM_FIELDS*VALUE_BITS-1:0] committed;
	logic [2:0] cflags;

	csp_front u_front (
		.clk, .arst_n, .rx_byte, .rx_valid(in_valid), .rx_ready(in_ready),
		.rec_valid, .rec, .rec_ready,
		.committed_values(committed), .committed_flags(cflags)
	);

	csp_back u_back (
		.clk, .arst_n, .rec_valid, .rec, .rec_ready,
		.committed_q(committed), .cflags_q(cflags),
		.out_valid, .out_ready, .out_ok(frame_ok),
		.good_q(good_frames), .bad_q(bad_frames)
	);

	// result fields
	assign heading     = committed[0*VALUE_BITS +: VALUE_BITS];
	assign pitch_angle = committed[1*VALUE_BITS +: VALUE_BITS];
	assign roll_angle  = committed[2*VALUE_BITS +: VALUE_BITS];
	assign mag_x       = committed[3*VALUE_BITS +: VALUE_BITS];
	assign mag_y       = committed[4*VALUE_BITS +: VALUE_BITS];
	assign mag_z       = committed[5*VALUE_BITS +: VALUE_BITS];
	assign magnetic_distortion = cflags[0];
	assign tilt_out_of_range   = cflags[1];
	assign mag_out_of_range    = cflags[2];
endmodule
`default_nettype wire

// ----- hdl/csp_checker.sv -----
// Port-level checks for the compass sentence parser.
// Bound to compass_sentence_parser.
`default_nettype none
module csp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic frame_ok,
	input wire logic [csp_pkg::COUNT_BITS-1:0] good_frames,
	input wire logic [csp_pkg::COUNT_BITS-1:0] bad_frames
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_ok))
		else $error("result dropped while stalled");
	// counters only move together with a new result
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !out_ready) && !$stable(good_frames) |-> out_valid && frame_ok)
		else $error("good count moved without a good frame");
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bad_frames) |-> out_valid && !frame_ok)
		else $error("bad count moved without a bad frame");
endmodule

bind compass_sentence_parser csp_checker u_csp_checker (
	.clk, .arst_n, .out_valid, .out_ready, .frame_ok, .good_frames, .bad_frames
);
`default_nettype wire

// ----- verif/compass_sentence_parser_tb.sv -----
// Self-checking bench for compass_sentence_parser: byte stream in, frame results out.
// Depends on hdl/csp_pkg.sv and hdl/compass_sentence_parser.sv.
`timescale 1ns / 1ps
module compass_sentence_parser_tb;
	import csp_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_HEX1 = 3'd2;
	localparam logic [2:0] PH_HEX2 = 3'd3;
	localparam logic [2:0] PH_CR   = 3'd4;
	localparam logic [2:0] PH_LF   = 3'd5;
	localparam logic [2:0] KEY_NONE  = 3'd0;
	localparam logic [2:0] KEY_FLAGS = 3'd7;
	localparam longint MAG_CAP = 64'd1 << (VALUE_BITS - 1);

	typedef struct packed {
		logic ok;
		logic [5:0][23:0] vals;
		logic [2:0] flags;
		logic [15:0] good;
		logic [15:0] bad;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic out_ready = 1'b0;
	logic in_ready, out_valid, frame_ok;
	logic signed [23:0] heading, pitch_angle, roll_angle, mag_x, mag_y, mag_z;
	logic magnetic_distortion, tilt_out_of_range, mag_out_of_range;
	logic [15:0] good_frames, bad_frames;

	compass_sentence_parser u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.rx_byte(rx_byte), .out_valid(out_valid), .out_ready(out_ready),
		.frame_ok(frame_ok), .heading(heading), .pitch_angle(pitch_angle),
		.roll_angle(roll_angle), .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.magnetic_distortion(magnetic_distortion),
		.tilt_out_of_range(tilt_out_of_range), .mag_out_of_range(mag_out_of_range),
		.good_frames(good_frames), .bad_frames(bad_frames)
	);

	// parser state mirrored for prediction
	logic [2:0] phase;
	logic [7:0] xsum;
	logic [15:0] hexrx;
	logic [2:0] key;
	longint acc;
	bit neg, pt, started, badf;
	int frac, foff;
	longint pend_v[6];
	longint comm_v[6];
	logic [2:0] pend_f, comm_f;
	logic [15:0] n_good, n_bad;

	frame_result_t expected_frames[$];
	logic [7:0] byte_queue[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	bit failed = 1'b0;
	int cycles = 0;

	function automatic longint mul_add_sat(longint a, longint d);
		longint r;
		r = a * 10 + d;
		return (r > MAG_CAP) ? MAG_CAP : r;
	endfunction

	function automatic logic [7:0] nib_hex(logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + n : 8'h41 + (n - 4'd10);
	endfunction

	// one-character string from a byte value
	function automatic string chr(int v);
		string s;
		s = " ";
		s[0] = 8'(v);
		return s;
	endfunction

	function automatic void open_key(logic [2:0] k);
		key = k; acc = 0; neg = 0; frac = 0; pt = 0; foff = 0;
		started = 0; badf = 0;
	endfunction

	function automatic void close_key();
		longint v, m;
		v = 0;
		if (key >= 3'd1 && key <= 3'd6) begin
			if (!badf && started) begin
				m = acc;
				for (int f = frac; f < 2; f++) m = mul_add_sat(m, 0);
				v = neg ? -m : ((m >= MAG_CAP) ? MAG_CAP - 1 : m);
			end
			pend_v[key - 1] = v;
		end
		key = KEY_NONE;
	endfunction

	function automatic void finish_frame(bit ok);
		frame_result_t r;
		if (ok) begin
			for (int i = 0; i < 6; i++) comm_v[i] = pend_v[i];
			comm_f = pend_f;
			n_good = n_good + 16'd1;
		end else begin
			n_bad = n_bad + 16'd1;
		end
		phase = PH_IDLE;
		key = KEY_NONE;
		r.ok = ok;
		for (int i = 0; i < 6; i++) r.vals[i] = comm_v[i][23:0];
		r.flags = comm_f;
		r.good = n_good;
		r.bad = n_bad;
		expected_frames.push_back(r);
	endfunction

	function automatic void field_char(logic [7:0] c);
		if (key == KEY_FLAGS) begin
			if (foff < 3) begin
				foff++;
				if (foff == 3) pend_f = c[2:0];
			end
			return;
		end
		if (key == KEY_NONE || badf) return;
		if ((c == "-" || c == "+") && !started) begin
			neg = (c == "-"); started = 1;
		end else if (c >= "0" && c <= "9") begin
			if (!(pt && frac >= 2)) begin
				acc = mul_add_sat(acc, c - "0");
				if (pt) frac++;
			end
			started = 1;
		end else if (c == "." && !pt) begin
			pt = 1; started = 1;
		end else begin
			badf = 1;
		end
	endfunction

	// predict the effect of one accepted byte
	function automatic void parse_byte(logic [7:0] c);
		int k;
		if (c == CH_DOLLAR) begin
			if (phase != PH_IDLE) finish_frame(0);
			phase = PH_BODY; xsum = 0; hexrx = 0;
			for (int i = 0; i < 6; i++) pend_v[i] = comm_v[i];
			pend_f = comm_f;
			open_key(KEY_NONE);
			return;
		end
		case (phase)
			PH_BODY: begin
				if (c == CH_CR || c == CH_LF) begin
					finish_frame(0);
				end else if (c == CH_STAR) begin
					close_key(); phase = PH_HEX1;
				end else begin
					xsum ^= c;
					k = 0;
					case (c)
						"C": k = 1;
						"P": k = 2;
						"R": k = 3;
						"X": k = 4;
						"Y": k = 5;
						"Z": k = 6;
						CH_E: k = 7;
						default: k = 0;
					endcase
					if (k != 0) begin
						close_key(); open_key(k[2:0]);
					end else begin
						field_char(c);
					end
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (c == CH_CR || c == CH_LF) finish_frame(0);
				else begin
					hexrx = {hexrx[7:0], c};
					phase = (phase == PH_HEX1) ? PH_HEX2 : PH_CR;
				end
			end
			PH_CR: begin
				if (c != CH_CR) finish_frame(0);
				else phase = PH_LF;
			end
			PH_LF: begin
				if (c != CH_LF) finish_frame(0);
				else finish_frame(hexrx == {nib_hex(xsum[7:4]), nib_hex(xsum[3:0])});
			end
			default: ;
		endcase
	endfunction

	// stimulus builders
	function automatic string rand_number();
		string s;
		int n;
		s = "";
		case ($urandom_range(0, 9))
			0: s = "+";
			1, 2: s = "-";
			default: ;
		endcase
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
		for (int i = 0; i < n; i++) s = {s, chr(8'h30 + $urandom_range(0, 9))};
		if ($urandom_range(0, 2) != 0) begin
			s = {s, "."};
			n = $urandom_range(0, 4);
			for (int i = 0; i < n; i++) s = {s, chr(8'h30 + $urandom_range(0, 9))};
		end
		if ($urandom_range(0, 19) == 0) s = {s, chr(8'h30 + $urandom_range(0, 79))};
		return s;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
	endfunction

	// body, checksum (optionally corrupted) and terminator
	function automatic void push_frame(string body, bit corrupt);
		logic [7:0] x;
		x = 0;
		for (int i = 0; i < body.len(); i++) x ^= body[i];
		if (corrupt) x ^= 8'h01 << $urandom_range(0, 7);
		push_text({"$", body, "*"});
		byte_queue.push_back(nib_hex(x[7:4]));
		byte_queue.push_back(nib_hex(x[3:0]));
		push_text("\r\n");
	endfunction

	function automatic string rand_body();
		string s;
		string keys;
		int n;
		keys = "CPRXYZE";
		s = "";
		if ($urandom_range(0, 9) == 0) s = "ab";
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				s = {s, "E"};
				for (int j = $urandom_range(0, 4); j > 0; j--)
					s = {s, chr(8'h30 + $urandom_range(0, 15))};
			end else begin
				s = {s, string'(keys[$urandom_range(0, 5)]), rand_number()};
			end
		end
		return s;
	endfunction

	function automatic void push_random_traffic();
		case ($urandom_range(0, 19))
			0: byte_queue.push_back(8'($urandom_range(0, 255)));
			1: begin
				push_text({"$", rand_body()});
				if ($urandom_range(0, 1)) byte_queue.push_back(CH_CR);
			end
			2: begin
				push_text({"$", rand_body(), "*4"});
				byte_queue.push_back(8'($urandom_range(0, 255)));
				byte_queue.push_back(8'($urandom_range(0, 255)));
			end
			3: push_frame(rand_body(), 1);
			default: push_frame(rand_body(), 0);
		endcase
	endfunction

	// clock and the single reset
	initial begin
		forever #4 clk = ~clk;
	end
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_byte(rx_byte);
				void'(byte_queue.pop_front());
			end
			if (in_valid && !in_ready) begin
			end else if (byte_queue.size() > 0 &&
				($urandom_range(0, 99) >= send_idle_pct)) begin
				in_valid <= 1'b1;
				rx_byte <= byte_queue[0];
			end else begin
				in_valid <= 1'b0;
				rx_byte <= 8'($urandom_range(0, 255));
			end
		end
	end

	// output ready, with its own long hold-off counter
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		frame_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_frames.size() == 0) begin
				$display("%0t: unexpected transaction ok=%0b good=%0d bad=%0d",
					$time, frame_ok, good_frames, bad_frames);
				failed = 1'b1;
			end else begin
				e = expected_frames.pop_front();
				if (e.ok !== frame_ok || e.vals[0] !== heading ||
					e.vals[1] !== pitch_angle || e.vals[2] !== roll_angle ||
					e.vals[3] !== mag_x || e.vals[4] !== mag_y || e.vals[5] !== mag_z ||
					e.flags !== {mag_out_of_range, tilt_out_of_range, magnetic_distortion} ||
					e.good !== good_frames || e.bad !== bad_frames) begin
					$display("%0t: mismatch exp ok=%0b v=%h f=%b g=%0d b=%0d", $time,
						e.ok, e.vals, e.flags, e.good, e.bad);
					$display("%0t:          act ok=%0b v=%h f=%b g=%0d b=%0d", $time,
						frame_ok, {mag_z, mag_y, mag_x, roll_angle, pitch_angle, heading},
						{mag_out_of_range, tilt_out_of_range, magnetic_distortion},
						good_frames, bad_frames);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("compass_sentence_parser_tb failed");
			$finish;
		end
	end

	task automatic drain_inputs();
		while (byte_queue.size() != 0 || in_valid) @(posedge clk);
	endtask

	task automatic wait_results();
		drain_inputs();
		while (expected_frames.size() != 0) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < 6; i++) begin
			pend_v[i] = 0; comm_v[i] = 0;
		end
		phase = PH_IDLE; xsum = 0; hexrx = 0; open_key(KEY_NONE);
		pend_f = 0; comm_f = 0; n_good = 0; n_bad = 0;
		@(posedge arst_n);

		// directed: extremes, saturation, truncation, empty and bad fields, flags
		push_text("zz");
		push_frame("C123.45P-0.5R+7X8388607Y-99999999Z.129E007", 0);
		push_frame("C-83886.08P83886.08R1.2.3X-Y+Z", 0);
		push_frame("junkCXE12", 0);
		push_frame("E00\xffC1C2", 0);
		push_frame("C5", 1);
		push_text("$C1\r");
		push_text("$C1*A\n");
		push_text("$C1*AB$P2*");
		byte_queue.push_back(8'h00);
		byte_queue.push_back(8'hFF);
		push_text("\r\r$*00x");
		push_frame("", 0);
		wait_results();

		// random phases with different input idling and output stalling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 15 : 47) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 15 : 47) : 0;
			if (ph == 1) hold_off = 3000;
			while (byte_queue.size() < 220)
				push_random_traffic();
			for (int n = 0; n < 3; n++) push_random_traffic();
			wait_results();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int n = 0; n < 5; n++) push_random_traffic();
		wait_results();
		repeat (20) @(posedge clk);
		if (!failed && expected_frames.size() == 0) begin
			$display("compass_sentence_parser_tb passed");
		end else begin
			$display("compass_sentence_parser_tb failed");
		end
		$finish;
	end
endmodule
